### src/vec3_pkg.sv
`timescale 1ns / 1ps
// vec3_pkg: operation and status codes of the vector unit.
// No dependencies; imported by vec3_alu.
package vec3_pkg;

  typedef enum logic [3:0] {
    FN_NEG   = 4'd0,
    FN_ADD   = 4'd1,
    FN_SUB   = 4'd2,
    FN_MUL   = 4'd3,
    FN_DIV   = 4'd4,
    FN_SADD  = 4'd5,
    FN_SSUB  = 4'd6,
    FN_SMUL  = 4'd7,
    FN_SDIV  = 4'd8,
    FN_LEN   = 4'd9,
    FN_NORM  = 4'd10,
    FN_DIR   = 4'd11,
    FN_DIST  = 4'd12,
    FN_DOT   = 4'd13,
    FN_CROSS = 4'd14
  } func_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_SAT  = 2'd1,
    ST_DIVZ = 2'd2
  } status_t;

endpackage

### src/vec3_alu.sv
`timescale 1ns / 1ps
// vec3_alu: pipelined three-component vector unit in signed fixed point.
// Depends on vec3_pkg (operation and status codes).
//
//  channel | valid/ready          | payload
//  --------+----------------------+---------------------------------------------
//  in      | in_tvalid/in_tready  | tdata a_x,a_y,a_z,b_x,b_y,b_z,scal; tuser func
//  out     | out_tvalid/out_tready| tdata res_x,res_y,res_z,res_scalar; tuser status
//
// One request per clock sustained while the skid register is empty. The pipeline
// length is set by the digit-per-stage square root (two radicand bits per stage)
// and the bit-per-stage dividers.
// Reset (rst_n low, synchronous) clears all valid bits; data regs are not reset.
// A skid register behind the output register takes one result while the output
// is stalled; the pipeline freezes only while the skid is full, so nothing is
// lost or repeated and in_tready is a flop output.
module vec3_alu
  import vec3_pkg::*;
#(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // a_x, a_y, a_z, b_x, b_y, b_z, scal (low to high), zero padded to bytes
  input  logic [((7*DATA_WIDTH+7)/8)*8-1:0] in_tdata,
  // func
  input  logic [3:0] in_tuser,
  output logic out_tvalid,
  input  logic out_tready,
  // res_x, res_y, res_z, res_scalar (low to high), zero padded to bytes
  output logic [((4*DATA_WIDTH+7)/8)*8-1:0] out_tdata,
  // status
  output logic [1:0] out_tuser
);

  localparam int W      = DATA_WIDTH;
  localparam int FB     = FRAC_BITS;
  localparam int OW     = W + 1;          // operand width, holds b - a
  localparam int PW     = 2 * OW;         // product width
  localparam int CW     = PW + 1;         // sum of products
  localparam int SQW    = PW;             // sum of squares, unsigned
  localparam int RW     = OW;             // square root width
  localparam int REMW   = RW + 3;         // root remainder
  localparam int NW     = OW + FB;        // dividend / quotient width
  localparam int VW     = (CW > NW + 1) ? CW : NW + 1;
  localparam int OUT_DW = ((4*DATA_WIDTH+7)/8)*8;

  localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

  typedef struct packed {
    func_t               op;
    logic [2:0][VW-1:0]  val;
    logic [VW-1:0]       sval;
    logic [2:0][OW-1:0]  num;
    logic [2:0][OW-1:0]  den;
    logic                zero;
  } pl_t;

  // {overflow, clamped value}
  function automatic logic [W:0] sat_f(input logic [VW-1:0] v);
    logic fits;
    fits = (v[VW-1:W-1] == {(VW-W+1){1'b0}}) || (v[VW-1:W-1] == {(VW-W+1){1'b1}});
    if (fits) sat_f = {1'b0, v[W-1:0]};
    else      sat_f = {1'b1, v[VW-1] ? MINV : MAXV};
  endfunction

  logic en;
  logic k_v_r, o_v_r;
  assign en        = !k_v_r;
  assign in_tready = en;

  // ---------------- stage 1: decode, operand select ----------------
  logic signed [OW-1:0] aw[3], bw[3], dw[3], sw;
  func_t                op_in;
  logic signed [OW-1:0] ma_nxt[6], mb_nxt[6], num_nxt[3], den_nxt[3], ear_nxt[3];

  always_comb begin
    op_in = func_t'(in_tuser);
    sw    = OW'($signed(in_tdata[6*W +: W]));
    for (int i = 0; i < 3; i++) begin
      aw[i] = OW'($signed(in_tdata[i*W +: W]));
      bw[i] = OW'($signed(in_tdata[(3+i)*W +: W]));
      dw[i] = bw[i] - aw[i];
    end
    for (int k = 0; k < 6; k++) begin
      ma_nxt[k] = '0;
      mb_nxt[k] = '0;
    end
    for (int i = 0; i < 3; i++) begin
      num_nxt[i] = '0;
      den_nxt[i] = '0;
      ear_nxt[i] = '0;
    end
    case (op_in)
      FN_NEG:  for (int i = 0; i < 3; i++) ear_nxt[i] = -aw[i];
      FN_ADD:  for (int i = 0; i < 3; i++) ear_nxt[i] = aw[i] + bw[i];
      FN_SUB:  for (int i = 0; i < 3; i++) ear_nxt[i] = aw[i] - bw[i];
      FN_SADD: for (int i = 0; i < 3; i++) ear_nxt[i] = aw[i] + sw;
      FN_SSUB: for (int i = 0; i < 3; i++) ear_nxt[i] = aw[i] - sw;
      FN_MUL, FN_DOT: begin
        for (int i = 0; i < 3; i++) begin
          ma_nxt[i] = aw[i];
          mb_nxt[i] = bw[i];
        end
      end
      FN_SMUL: begin
        for (int i = 0; i < 3; i++) begin
          ma_nxt[i] = aw[i];
          mb_nxt[i] = sw;
        end
      end
      FN_DIV: begin
        for (int i = 0; i < 3; i++) begin
          num_nxt[i] = aw[i];
          den_nxt[i] = bw[i];
        end
      end
      FN_SDIV: begin
        for (int i = 0; i < 3; i++) begin
          num_nxt[i] = aw[i];
          den_nxt[i] = sw;
        end
      end
      FN_LEN, FN_NORM: begin
        for (int i = 0; i < 3; i++) begin
          ma_nxt[i]  = aw[i];
          mb_nxt[i]  = aw[i];
          num_nxt[i] = aw[i];
        end
      end
      FN_DIR, FN_DIST: begin
        for (int i = 0; i < 3; i++) begin
          ma_nxt[i]  = dw[i];
          mb_nxt[i]  = dw[i];
          num_nxt[i] = dw[i];
        end
      end
      FN_CROSS: begin
        // x: ay*bz - az*by, y: az*bx - ax*bz, z: ax*by - ay*bx
        ma_nxt[0] = aw[1]; mb_nxt[0] = bw[2]; ma_nxt[3] = aw[2]; mb_nxt[3] = bw[1];
        ma_nxt[1] = aw[2]; mb_nxt[1] = bw[0]; ma_nxt[4] = aw[0]; mb_nxt[4] = bw[2];
        ma_nxt[2] = aw[0]; mb_nxt[2] = bw[1]; ma_nxt[5] = aw[1]; mb_nxt[5] = bw[0];
      end
      default: ;
    endcase
  end

  func_t                op1_r, op2_r;
  logic                 v1_r, v2_r;
  logic signed [OW-1:0] ma1_r[6], mb1_r[6];
  logic signed [OW-1:0] num1_r[3], den1_r[3], ear1_r[3];
  logic signed [OW-1:0] num2_r[3], den2_r[3], ear2_r[3];
  logic signed [PW-1:0] p2_r[6];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_tvalid;
      v2_r <= v1_r;
    end
    if (en) begin
      op1_r <= op_in;
      for (int k = 0; k < 6; k++) begin
        ma1_r[k] <= ma_nxt[k];
        mb1_r[k] <= mb_nxt[k];
        p2_r[k]  <= ma1_r[k] * mb1_r[k];   // stage 2: products
      end
      for (int i = 0; i < 3; i++) begin
        num1_r[i] <= num_nxt[i];
        den1_r[i] <= den_nxt[i];
        ear1_r[i] <= ear_nxt[i];
        num2_r[i] <= num1_r[i];
        den2_r[i] <= den1_r[i];
        ear2_r[i] <= ear1_r[i];
      end
      op2_r <= op1_r;
    end
  end

  // ---------------- stage 3: combine products ----------------
  logic signed [CW-1:0] sum3;
  pl_t                  pl3_nxt;

  always_comb begin
    sum3 = CW'(p2_r[0]) + CW'(p2_r[1]) + CW'(p2_r[2]);
    pl3_nxt      = '0;
    pl3_nxt.op   = op2_r;
    pl3_nxt.zero = (sum3[SQW-1:0] == '0);
    for (int i = 0; i < 3; i++) begin
      pl3_nxt.num[i] = num2_r[i];
      pl3_nxt.den[i] = den2_r[i];
    end
    case (op2_r)
      FN_NEG, FN_ADD, FN_SUB, FN_SADD, FN_SSUB:
        for (int i = 0; i < 3; i++) pl3_nxt.val[i] = VW'(ear2_r[i]);
      FN_MUL, FN_SMUL:
        for (int i = 0; i < 3; i++) pl3_nxt.val[i] = VW'(p2_r[i]) >>> FB;
      FN_CROSS:
        for (int i = 0; i < 3; i++)
          pl3_nxt.val[i] = (VW'(p2_r[i]) - VW'(p2_r[i+3])) >>> FB;
      FN_DOT: pl3_nxt.sval = VW'(sum3) >>> FB;
      default: ;
    endcase
  end

  // ---------------- square root, two radicand bits per stage ----------------
  pl_t             sq_pl_r  [RW+1];
  logic [REMW-1:0] sq_rem_r [RW+1];
  logic [RW-1:0]   sq_root_r[RW+1];
  logic [SQW-1:0]  sq_rad_r [RW+1];
  logic            sq_v_r   [RW+1];

  always_ff @(posedge clk) begin
    if (!rst_n) sq_v_r[0] <= 1'b0;
    else if (en) sq_v_r[0] <= v2_r;
    if (en) begin
      sq_pl_r[0]   <= pl3_nxt;
      sq_rem_r[0]  <= '0;
      sq_root_r[0] <= '0;
      sq_rad_r[0]  <= sum3[SQW-1:0];
    end
  end

  for (genvar j = 0; j < RW; j++) begin : g_sqrt
    logic [REMW-1:0] remsh, trial;
    logic            ge;
    always_comb begin
      remsh = {sq_rem_r[j][REMW-3:0], sq_rad_r[j][SQW-1 -: 2]};
      trial = REMW'({sq_root_r[j], 2'b01});
      ge    = (remsh >= trial);
    end
    always_ff @(posedge clk) begin
      if (!rst_n) sq_v_r[j+1] <= 1'b0;
      else if (en) sq_v_r[j+1] <= sq_v_r[j];
      if (en) begin
        sq_pl_r[j+1]   <= sq_pl_r[j];
        sq_rem_r[j+1]  <= ge ? remsh - trial : remsh;
        sq_root_r[j+1] <= {sq_root_r[j][RW-2:0], ge};
        sq_rad_r[j+1]  <= {sq_rad_r[j][SQW-3:0], 2'b00};
      end
    end
  end

  // ---------------- divider setup: magnitudes and quotient sign ----------------
  pl_t           pld_nxt;
  logic [NW-1:0] nm_nxt[3];
  logic [OW-1:0] dm_nxt[3];
  logic [2:0]    neg_nxt;
  logic          is_norm_d;

  always_comb begin
    logic signed [OW-1:0] nv, dv;
    logic [OW-1:0]        nmag;
    pld_nxt   = sq_pl_r[RW];
    is_norm_d = (pld_nxt.op inside {FN_NORM, FN_DIR});
    if (pld_nxt.op inside {FN_LEN, FN_DIST}) pld_nxt.sval = VW'(sq_root_r[RW]);
    for (int i = 0; i < 3; i++) begin
      nv         = $signed(pld_nxt.num[i]);
      dv         = $signed(pld_nxt.den[i]);
      nmag       = nv[OW-1] ? OW'(-nv) : nv;
      nm_nxt[i]  = {nmag, {FB{1'b0}}};
      dm_nxt[i]  = is_norm_d ? sq_root_r[RW] : (dv[OW-1] ? OW'(-dv) : dv);
      neg_nxt[i] = nv[OW-1] ^ (dv[OW-1] & !is_norm_d);
    end
  end

  // ---------------- restoring dividers, one quotient bit per stage ----------------
  pl_t           dv_pl_r [NW+1];
  logic [NW-1:0] dv_q_r  [NW+1][3];
  logic [OW:0]   dv_rm_r [NW+1][3];
  logic [OW-1:0] dv_dm_r [NW+1][3];
  logic [2:0]    dv_neg_r[NW+1];
  logic          dv_v_r  [NW+1];

  always_ff @(posedge clk) begin
    if (!rst_n) dv_v_r[0] <= 1'b0;
    else if (en) dv_v_r[0] <= sq_v_r[RW];
    if (en) begin
      dv_pl_r[0]  <= pld_nxt;
      dv_neg_r[0] <= neg_nxt;
      for (int i = 0; i < 3; i++) begin
        dv_q_r[0][i]  <= nm_nxt[i];
        dv_rm_r[0][i] <= '0;
        dv_dm_r[0][i] <= dm_nxt[i];
      end
    end
  end

  for (genvar j = 0; j < NW; j++) begin : g_div
    logic [OW:0] rsh[3];
    logic [2:0]  ge;
    always_comb begin
      for (int i = 0; i < 3; i++) begin
        rsh[i] = {dv_rm_r[j][i][OW-1:0], dv_q_r[j][i][NW-1]};
        ge[i]  = (rsh[i] >= {1'b0, dv_dm_r[j][i]});
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) dv_v_r[j+1] <= 1'b0;
      else if (en) dv_v_r[j+1] <= dv_v_r[j];
      if (en) begin
        dv_pl_r[j+1]  <= dv_pl_r[j];
        dv_neg_r[j+1] <= dv_neg_r[j];
        for (int i = 0; i < 3; i++) begin
          dv_rm_r[j+1][i] <= ge[i] ? rsh[i] - {1'b0, dv_dm_r[j][i]} : rsh[i];
          dv_q_r[j+1][i]  <= {dv_q_r[j][i][NW-2:0], ge[i]};
          dv_dm_r[j+1][i] <= dv_dm_r[j][i];
        end
      end
    end
  end

  // ---------------- final: sign, saturation, status ----------------
  pl_t             plf;
  logic [W-1:0]    res[3];
  logic [W:0]      sres[3];
  logic [W:0]      sscal;
  logic [VW-1:0]   qs;
  logic            any_sat, any_dz, is_div_f, is_norm_f;
  status_t         st_f;
  logic [OUT_DW-1:0] data_f;

  always_comb begin
    plf       = dv_pl_r[NW];
    is_div_f  = (plf.op inside {FN_DIV, FN_SDIV});
    is_norm_f = (plf.op inside {FN_NORM, FN_DIR});
    any_sat   = 1'b0;
    any_dz    = 1'b0;
    qs        = '0;
    for (int i = 0; i < 3; i++) begin
      qs      = VW'(dv_q_r[NW][i]);
      qs      = dv_neg_r[NW][i] ? -qs : qs;
      sres[i] = sat_f(plf.val[i]);
      if (is_div_f && dv_dm_r[NW][i] == '0) begin
        // divide by zero: sign of the dividend picks the bound
        res[i] = dv_neg_r[NW][i] ? MINV : MAXV;
        any_dz = 1'b1;
      end else if (is_norm_f && plf.zero) begin
        res[i] = MAXV;
        any_dz = 1'b1;
      end else if (is_div_f || is_norm_f) begin
        sres[i] = sat_f(qs);
        res[i]  = sres[i][W-1:0];
        any_sat = any_sat | sres[i][W];
      end else begin
        res[i]  = sres[i][W-1:0];
        any_sat = any_sat | sres[i][W];
      end
    end
    sscal   = sat_f(plf.sval);
    any_sat = any_sat | sscal[W];
    if (any_dz)       st_f = ST_DIVZ;
    else if (any_sat) st_f = ST_SAT;
    else              st_f = ST_OK;
    data_f = OUT_DW'({sscal[W-1:0], res[2], res[1], res[0]});
  end

  // ---------------- output register and skid ----------------
  logic [OUT_DW-1:0] o_data_r, k_data_r;
  logic [1:0]        o_user_r, k_user_r;
  logic              last_v;
  assign last_v = dv_v_r[NW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_v_r <= 1'b0;
      k_v_r <= 1'b0;
    end else if (!o_v_r || out_tready) begin
      if (k_v_r) begin
        o_v_r <= 1'b1;
        k_v_r <= 1'b0;
      end else begin
        o_v_r <= last_v;
      end
    end else if (en && last_v) begin
      k_v_r <= 1'b1;
    end
    if (!o_v_r || out_tready) begin
      o_data_r <= k_v_r ? k_data_r : data_f;
      o_user_r <= k_v_r ? k_user_r : st_f;
    end else if (en && last_v) begin
      k_data_r <= data_f;
      k_user_r <= st_f;
    end
  end

  assign out_tvalid = o_v_r;
  assign out_tdata  = o_data_r;
  assign out_tuser  = o_user_r;

  // ---------------- assertions ----------------
  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    k_v_r |-> o_v_r) else $error("skid full with output register empty");

  a_skid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (k_v_r && !out_tready) |=> (k_v_r && $stable(k_data_r)))
    else $error("skid result lost under stall");

  a_divz_no_scalar: assert property (@(posedge clk) disable iff (!rst_n)
    (o_v_r && o_user_r == ST_DIVZ) |-> (o_data_r[3*W +: W] == '0))
    else $error("zero-divide status with scalar result");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!o_v_r && !k_v_r)) else $error("valid after reset");

endmodule
